// ===== hdl/lafm_pkg.sv =====
// Shared types and constants for the look-at frame matrix unit.
`default_nettype none
package lafm_pkg;
	typedef logic signed [31:0] fx_t;
	// Three lanes; lane 0 is x.
	typedef logic [2:0][31:0] vec3_t;
	typedef logic [1:0] row_idx_t;

	localparam row_idx_t ROW_X   = 2'd0;
	localparam row_idx_t ROW_Y   = 2'd1;
	localparam row_idx_t ROW_Z   = 2'd2;
	localparam row_idx_t ROW_POS = 2'd3;

	typedef struct packed {
		fx_t pos_x;
		fx_t pos_y;
		fx_t pos_z;
		fx_t dir_x;
		fx_t dir_y;
		fx_t dir_z;
		fx_t up_x;
		fx_t up_y;
		fx_t up_z;
	} cmd_t;

	typedef struct packed {
		row_idx_t row_index;
		fx_t      elem_0;
		fx_t      elem_1;
		fx_t      elem_2;
		fx_t      elem_w;
		logic     degenerate;
		logic     last_row;
	} result_t;
endpackage
`default_nettype wire

// ===== hdl/lafm_norm.sv =====
// Pipelined vector normaliser: squares, digit-per-stage square root, bit-per-stage divide.
`default_nettype none
module lafm_norm #(
	parameter int F      = 16,
	parameter int SIDE_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire lafm_pkg::vec3_t    in_vec,
	input  wire logic               in_deg,
	input  wire logic [SIDE_W-1:0]  in_side,
	output logic                    out_valid,
	output lafm_pkg::vec3_t         out_vec,
	output logic                    out_deg,
	output logic [SIDE_W-1:0]       out_side
);
	import lafm_pkg::*;

	localparam int NW = 33 + F;   // numerator width: mag << F plus half length
	localparam int DS = F + 1;    // quotient bits, result never above 1.0
	localparam int RS = 32;       // root bits

	typedef struct packed {
		logic [2:0][31:0]   mag;
		logic [2:0]         neg;
		logic               deg;
		logic [SIDE_W-1:0]  side;
	} carry_t;

	// stage 1: magnitudes
	logic   v_s1;
	carry_t c_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s1.neg[i] <= in_vec[i][31];
			c_s1.mag[i] <= in_vec[i][31] ? 32'(-in_vec[i]) : in_vec[i];
		end
		c_s1.deg  <= in_deg;
		c_s1.side <= in_side;
	end

	// stage 2: squares
	logic        v_s2;
	carry_t      c_s2;
	logic [63:0] sq_s2 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s2[i] <= 64'(c_s1.mag[i]) * 64'(c_s1.mag[i]);
		c_s2 <= c_s1;
	end

	// root pipeline, entry 0 is the sum of squares
	logic        rt_v_s    [0:RS];
	carry_t      rt_c_s    [0:RS];
	logic [63:0] rt_rem_s  [0:RS];
	logic [31:0] rt_root_s [0:RS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s[0] <= 1'b0;
		else rt_v_s[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		rt_rem_s[0]  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		rt_root_s[0] <= '0;
		rt_c_s[0]    <= c_s2;
	end

	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam int B = RS - 1 - k;
		logic [64:0] trial;
		logic        take;
		// (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
		assign trial = (65'(rt_root_s[k]) << (B + 1)) | (65'd1 << (2 * B));
		assign take  = {1'b0, rt_rem_s[k]} >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k+1] <= 1'b0;
			else rt_v_s[k+1] <= rt_v_s[k];
		end
		always_ff @(posedge clk) begin
			rt_c_s[k+1] <= rt_c_s[k];
			if (take) begin
				rt_rem_s[k+1]  <= rt_rem_s[k] - trial[63:0];
				rt_root_s[k+1] <= rt_root_s[k] | (32'd1 << B);
			end else begin
				rt_rem_s[k+1]  <= rt_rem_s[k];
				rt_root_s[k+1] <= rt_root_s[k];
			end
		end
	end

	// divide pipeline, entry 0 holds rounded numerators
	logic          dv_v_s   [0:DS];
	carry_t        dv_c_s   [0:DS];
	logic [31:0]   dv_len_s [0:DS];
	logic [NW-1:0] dv_rem_s [0:DS][3];
	logic [DS-1:0] dv_q_s   [0:DS][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else dv_v_s[0] <= rt_v_s[RS];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (NW'(rt_c_s[RS].mag[i]) << F) + NW'(rt_root_s[RS] >> 1);
			dv_q_s[0][i]   <= '0;
		end
		dv_len_s[0] <= rt_root_s[RS];
		dv_c_s[0]   <= rt_c_s[RS];
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		localparam int B = DS - 1 - k;
		logic [NW-1:0] dsub;
		assign dsub = NW'(dv_len_s[k]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else dv_v_s[k+1] <= dv_v_s[k];
		end
		always_ff @(posedge clk) begin
			dv_len_s[k+1] <= dv_len_s[k];
			dv_c_s[k+1]   <= dv_c_s[k];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[k][i] >= dsub) begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i] - dsub;
					dv_q_s[k+1][i]   <= dv_q_s[k][i] | (DS'(1) << B);
				end else begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i];
					dv_q_s[k+1][i]   <= dv_q_s[k][i];
				end
			end
		end
	end

	// output: sign back on, zero length forces zeros
	logic zero_len;
	assign zero_len = (dv_len_s[DS] == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= dv_v_s[DS];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (zero_len) out_vec[i] <= '0;
			else if (dv_c_s[DS].neg[i]) out_vec[i] <= 32'(-(32'(dv_q_s[DS][i])));
			else out_vec[i] <= 32'(dv_q_s[DS][i]);
		end
		out_deg  <= dv_c_s[DS].deg | zero_len;
		out_side <= dv_c_s[DS].side;
	end
endmodule
`default_nettype wire

// ===== hdl/lafm_cross.sv =====
// Three-stage cross product a x b with rounding back to F fraction bits.
`default_nettype none
module lafm_cross #(
	parameter int F      = 16,
	parameter int SIDE_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire lafm_pkg::vec3_t    in_a,
	input  wire lafm_pkg::vec3_t    in_b,
	input  wire logic [SIDE_W-1:0]  in_side,
	output logic                    out_valid,
	output lafm_pkg::vec3_t         out_vec,
	output logic [SIDE_W-1:0]       out_side
);
	import lafm_pkg::*;

	logic               v_s1, v_s2;
	logic signed [63:0] p_s1 [6];
	logic signed [64:0] d_s2 [3];
	logic [SIDE_W-1:0]  side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= $signed(in_a[1]) * $signed(in_b[2]);
		p_s1[1] <= $signed(in_a[2]) * $signed(in_b[1]);
		p_s1[2] <= $signed(in_a[2]) * $signed(in_b[0]);
		p_s1[3] <= $signed(in_a[0]) * $signed(in_b[2]);
		p_s1[4] <= $signed(in_a[0]) * $signed(in_b[1]);
		p_s1[5] <= $signed(in_a[1]) * $signed(in_b[0]);
		side_s1 <= in_side;
		for (int i = 0; i < 3; i++)
			d_s2[i] <= 65'(p_s1[2*i]) - 65'(p_s1[2*i+1]);
		side_s2  <= side_s1;
		out_side <= side_s2;
	end

	// round half away from zero
	logic [64:0] mag [3];
	logic [64:0] rnd [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = d_s2[i][64] ? 65'(-d_s2[i]) : 65'(d_s2[i]);
			rnd[i] = (mag[i] + (65'd1 << (F - 1))) >> F;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			out_vec[i] <= d_s2[i][64] ? 32'(-rnd[i]) : rnd[i][31:0];
	end
endmodule
`default_nettype wire

// ===== hdl/lafm_rows.sv =====
// Row sequencer: holds a finished frame and emits its four rows, one per cycle.
`default_nettype none
module lafm_rows #(
	parameter int F = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire lafm_pkg::vec3_t   in_x,
	input  wire lafm_pkg::vec3_t   in_y,
	input  wire lafm_pkg::vec3_t   in_z,
	input  wire lafm_pkg::vec3_t   in_pos,
	input  wire logic              in_deg,
	output logic                   done,
	output lafm_pkg::result_t      result
);
	import lafm_pkg::*;

	localparam logic [31:0] ONE_FX = 32'd1 << F;

	logic     act_q;
	row_idx_t row_q;
	vec3_t    x_q, y_q, z_q, pos_q;
	logic     deg_q;
	vec3_t    sel;

	// frames arrive no faster than their rows are emitted, so a load never cuts a frame short
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			row_q <= ROW_X;
		end else if (in_valid) begin
			act_q <= 1'b1;
			row_q <= ROW_X;
		end else if (act_q) begin
			row_q <= row_q + 2'd1;
			if (row_q == ROW_POS) act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			x_q   <= in_x;
			y_q   <= in_y;
			z_q   <= in_z;
			pos_q <= in_pos;
			deg_q <= in_deg;
		end
	end

	always_comb begin
		case (row_q)
			ROW_X:   sel = x_q;
			ROW_Y:   sel = y_q;
			ROW_Z:   sel = z_q;
			ROW_POS: sel = pos_q;
			default: sel = pos_q;
		endcase
	end

	assign done              = act_q;
	assign result.row_index  = row_q;
	assign result.elem_0     = sel[0];
	assign result.elem_1     = sel[1];
	assign result.elem_2     = sel[2];
	assign result.elem_w     = (row_q == ROW_POS) ? ONE_FX : 32'd0;
	assign result.degenerate = deg_q;
	assign result.last_row   = (row_q == ROW_POS);
endmodule
`default_nettype wire

// ===== hdl/look_at_frame_matrix_unit.sv =====
// Top level of the look-at frame matrix unit.
// Usage:
//  A command (position, direction, up vector, signed fixed point with
//  FRAC_BITS fraction bits) is taken on a rising edge with start high and
//  busy low. busy stays high after each command, so commands are taken no
//  closer together than their four result beats last.
//  Each command yields four beats on result, one per cycle, each marked by
//  done for exactly one cycle: x axis, y axis, z axis, then position with
//  w = 1.0. degenerate is the same on all four beats; last_row marks the 4th.
//  From accept to the first beat a command passes three normalisers in
//  series (squares, one root bit per stage over 32 stages, one quotient
//  bit per stage over FRAC_BITS+1 stages), two 3-stage cross product units
//  and the row sequencer.
//  The pipeline never stalls; the receiver must take every beat as shown.
//  Reset clears all valid bits and the sequencer; no beats follow reset
//  until a new command is taken.
`default_nettype none
module look_at_frame_matrix_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire lafm_pkg::cmd_t    cmd,
	output logic                   done,
	output lafm_pkg::result_t      result
);
	import lafm_pkg::*;

	logic [1:0] hold_q;
	logic       accept;

	assign accept = start && !busy;
	assign busy   = (hold_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_q <= 2'd0;
		else if (accept) hold_q <= 2'd3;
		else if (hold_q != 2'd0) hold_q <= hold_q - 2'd1;
	end

	vec3_t pos_in, dir_in, up_in;
	assign pos_in = {cmd.pos_z, cmd.pos_y, cmd.pos_x};
	assign dir_in = {cmd.dir_z, cmd.dir_y, cmd.dir_x};
	assign up_in  = {cmd.up_z, cmd.up_y, cmd.up_x};

	// z axis and up axis in parallel
	logic  nz_valid, nz_deg, nu_valid, nu_deg;
	vec3_t nz_vec, nz_pos, nu_vec;
	logic  nu_side;

	lafm_norm #(.F(FRAC_BITS), .SIDE_W(96)) u_norm_z (
		.clk(clk), .arst_n(arst_n),
		.in_valid(accept), .in_vec(dir_in), .in_deg(1'b0), .in_side(pos_in),
		.out_valid(nz_valid), .out_vec(nz_vec), .out_deg(nz_deg), .out_side(nz_pos)
	);

	lafm_norm #(.F(FRAC_BITS), .SIDE_W(1)) u_norm_u (
		.clk(clk), .arst_n(arst_n),
		.in_valid(accept), .in_vec(up_in), .in_deg(1'b0), .in_side(accept),
		.out_valid(nu_valid), .out_vec(nu_vec), .out_deg(nu_deg), .out_side(nu_side)
	);

	// x raw = u x z; side carries {deg, pos, z}
	logic         c1_valid;
	vec3_t        c1_vec;
	logic [192:0] c1_side;

	lafm_cross #(.F(FRAC_BITS), .SIDE_W(193)) u_cross_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(nz_valid && nu_valid && nu_side), .in_a(nu_vec), .in_b(nz_vec),
		.in_side({nz_deg | nu_deg, nz_pos, nz_vec}),
		.out_valid(c1_valid), .out_vec(c1_vec), .out_side(c1_side)
	);

	logic         nx_valid, nx_deg;
	vec3_t        nx_vec;
	logic [191:0] nx_side;

	lafm_norm #(.F(FRAC_BITS), .SIDE_W(192)) u_norm_x (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c1_valid), .in_vec(c1_vec), .in_deg(c1_side[192]),
		.in_side(c1_side[191:0]),
		.out_valid(nx_valid), .out_vec(nx_vec), .out_deg(nx_deg), .out_side(nx_side)
	);

	// y raw = z x x; side carries {deg, pos, z, x}
	logic         c2_valid;
	vec3_t        c2_vec;
	logic [288:0] c2_side;

	lafm_cross #(.F(FRAC_BITS), .SIDE_W(289)) u_cross_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(nx_valid), .in_a(nx_side[95:0]), .in_b(nx_vec),
		.in_side({nx_deg, nx_side, nx_vec}),
		.out_valid(c2_valid), .out_vec(c2_vec), .out_side(c2_side)
	);

	logic         ny_valid, ny_deg;
	vec3_t        ny_vec;
	logic [287:0] ny_side;

	lafm_norm #(.F(FRAC_BITS), .SIDE_W(288)) u_norm_y (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c2_valid), .in_vec(c2_vec), .in_deg(c2_side[288]),
		.in_side(c2_side[287:0]),
		.out_valid(ny_valid), .out_vec(ny_vec), .out_deg(ny_deg), .out_side(ny_side)
	);

	lafm_rows #(.F(FRAC_BITS)) u_rows (
		.clk(clk), .arst_n(arst_n),
		.in_valid(ny_valid),
		.in_x(ny_side[95:0]),
		.in_y(ny_vec),
		.in_z(ny_side[191:96]),
		.in_pos(ny_side[287:192]),
		.in_deg(ny_deg),
		.done(done), .result(result)
	);
endmodule
`default_nettype wire

// ===== tb/look_at_frame_matrix_unit_tb.sv =====
// Self-checking testbench for the look-at frame matrix unit.
`timescale 1ns / 1ps
module look_at_frame_matrix_unit_tb;
	import lafm_pkg::*;

	localparam int FRAC = 16;
	localparam fx_t ONE = 32'sd65536;
	localparam int LATENCY = 3 * FRAC + 121;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM = 450;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	result_t frame_rows_q[$];
	int      errors;
	int      beats_seen;
	int      degen_seen;
	int      cycles;

	look_at_frame_matrix_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Unit vector; returns 1 when the length is zero.
	function automatic bit unit_vec(input longint v[3], output longint u[3]);
		longint unsigned m[3];
		longint unsigned s;
		longint unsigned len;
		longint unsigned q;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (v[i] < 0) ? -v[i] : v[i];
			s += m[i] * m[i];
		end
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (len == 0) ? 64'd0 : ((m[i] << FRAC) + (len >> 1)) / len;
			u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return len == 0;
	endfunction

	function automatic longint round_frac(input longint p);
		longint unsigned m;
		m = (p < 0) ? -p : p;
		m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
		return (p < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
			output longint c[3]);
		c[0] = round_frac(a[1] * b[2] - a[2] * b[1]);
		c[1] = round_frac(a[2] * b[0] - a[0] * b[2]);
		c[2] = round_frac(a[0] * b[1] - a[1] * b[0]);
	endfunction

	task automatic predict_frame(input cmd_t c);
		longint d[3], u[3], z[3], un[3], xr[3], x[3], yr[3], y[3];
		bit degen;
		result_t r;
		d = '{longint'(c.dir_x), longint'(c.dir_y), longint'(c.dir_z)};
		u = '{longint'(c.up_x), longint'(c.up_y), longint'(c.up_z)};
		degen = unit_vec(d, z);
		degen |= unit_vec(u, un);
		cross_prod(un, z, xr);
		degen |= unit_vec(xr, x);
		cross_prod(z, x, yr);
		degen |= unit_vec(yr, y);
		r.degenerate = degen;
		r.elem_w = '0;
		r.last_row = 1'b0;
		r.row_index = ROW_X;
		r.elem_0 = fx_t'(x[0]); r.elem_1 = fx_t'(x[1]); r.elem_2 = fx_t'(x[2]);
		frame_rows_q.push_back(r);
		r.row_index = ROW_Y;
		r.elem_0 = fx_t'(y[0]); r.elem_1 = fx_t'(y[1]); r.elem_2 = fx_t'(y[2]);
		frame_rows_q.push_back(r);
		r.row_index = ROW_Z;
		r.elem_0 = fx_t'(z[0]); r.elem_1 = fx_t'(z[1]); r.elem_2 = fx_t'(z[2]);
		frame_rows_q.push_back(r);
		r.row_index = ROW_POS;
		r.elem_0 = c.pos_x; r.elem_1 = c.pos_y; r.elem_2 = c.pos_z;
		r.elem_w = ONE;
		r.last_row = 1'b1;
		frame_rows_q.push_back(r);
	endtask

	// Result beat checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (frame_rows_q.size() == 0) begin
				$error("unexpected beat: row_index %0d", result.row_index);
				errors++;
			end else begin
				result_t e;
				e = frame_rows_q.pop_front();
				beats_seen++;
				if (e.degenerate && e.last_row) degen_seen++;
				if (result.row_index !== e.row_index) begin
					$error("row_index exp %0d got %0d", e.row_index, result.row_index);
					errors++;
				end
				if (result.elem_0 !== e.elem_0) begin
					$error("elem_0 exp %0d got %0d", e.elem_0, result.elem_0);
					errors++;
				end
				if (result.elem_1 !== e.elem_1) begin
					$error("elem_1 exp %0d got %0d", e.elem_1, result.elem_1);
					errors++;
				end
				if (result.elem_2 !== e.elem_2) begin
					$error("elem_2 exp %0d got %0d", e.elem_2, result.elem_2);
					errors++;
				end
				if (result.elem_w !== e.elem_w) begin
					$error("elem_w exp %0d got %0d", e.elem_w, result.elem_w);
					errors++;
				end
				if (result.degenerate !== e.degenerate) begin
					$error("degenerate exp %0b got %0b", e.degenerate, result.degenerate);
					errors++;
				end
				if (result.last_row !== e.last_row) begin
					$error("last_row exp %0b got %0b", e.last_row, result.last_row);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t rows[4];
	} stim_row_t;

	stim_row_t stim_tab[$];

	function automatic cmd_t mk_cmd(input fx_t px, py, pz, dx, dy, dz, ux, uy, uz);
		cmd_t c;
		c = '{px, py, pz, dx, dy, dz, ux, uy, uz};
		return c;
	endfunction

	function automatic result_t mk_row(input row_idx_t ri, input fx_t a, b, c, w,
			input logic dg);
		result_t r;
		r = '{ri, a, b, c, w, dg, ri == ROW_POS};
		return r;
	endfunction

	function automatic fx_t rnd_small();
		return fx_t'($urandom_range(0, 1 << 18)) - (fx_t'(1) <<< 17);
	endfunction

	function automatic cmd_t rnd_cmd();
		cmd_t c;
		int k;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				c.dir_x = rnd_small(); c.dir_y = rnd_small(); c.dir_z = rnd_small();
				c.up_x = rnd_small(); c.up_y = rnd_small(); c.up_z = rnd_small();
			end
			4: begin
				// up parallel to direction: x axis collapses
				k = $urandom_range(1, 7);
				c.dir_x = rnd_small(); c.dir_y = rnd_small(); c.dir_z = rnd_small();
				c.up_x = c.dir_x * k; c.up_y = c.dir_y * k; c.up_z = c.dir_z * k;
			end
			5: begin
				if ($urandom_range(0, 1)) {c.dir_x, c.dir_y, c.dir_z} = '0;
				else {c.up_x, c.up_y, c.up_z} = '0;
			end
			6: begin
				c.dir_x = $urandom_range(0, 1) ? 32'sh0 : c.dir_x;
				c.up_y = $urandom_range(0, 1) ? 32'sh0 : c.up_y;
				c.dir_z = $urandom_range(0, 3) - 2;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_frame(input cmd_t c, input bit typed, input result_t rows[4],
			input bit allow_idle);
		if (allow_idle && $urandom_range(0, 99) < 28) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (typed) for (int i = 0; i < 4; i++) frame_rows_q.push_back(rows[i]);
		else predict_frame(c);
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		while (frame_rows_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		stim_row_t s;
		result_t none[4];
		fx_t mx, mn;
		errors = 0; beats_seen = 0; degen_seen = 0; cycles = 0;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		none = '{default: '0};

		// identity frame
		s.c = mk_cmd(0, 0, 0, 0, 0, ONE, 0, ONE, 0);
		s.typed = 1;
		s.rows = '{mk_row(ROW_X, ONE, 0, 0, 0, 0), mk_row(ROW_Y, 0, ONE, 0, 0, 0),
			mk_row(ROW_Z, 0, 0, ONE, 0, 0), mk_row(ROW_POS, 0, 0, 0, ONE, 0)};
		stim_tab.push_back(s);
		// zero direction and up: all axes zero
		s.c = mk_cmd(mx, mn, -1, 0, 0, 0, 0, 0, 0);
		s.rows = '{mk_row(ROW_X, 0, 0, 0, 0, 1), mk_row(ROW_Y, 0, 0, 0, 0, 1),
			mk_row(ROW_Z, 0, 0, 0, 0, 1), mk_row(ROW_POS, mx, mn, -1, ONE, 1)};
		stim_tab.push_back(s);
		s.typed = 0;
		s.rows = none;
		s.c = mk_cmd(mx, mx, mx, mx, mx, mx, mx, mx, mx); stim_tab.push_back(s);
		s.c = mk_cmd(mn, mn, mn, mn, mn, mn, mn, mn, mn); stim_tab.push_back(s);
		s.c = mk_cmd(mn, mx, 0, mn, 0, 0, 0, mx, 0); stim_tab.push_back(s);
		s.c = mk_cmd(1, -1, 0, mx, mn, mx, mn, mx, mn); stim_tab.push_back(s);
		s.c = mk_cmd(0, 0, 0, 1, 0, 0, 0, 0, 1); stim_tab.push_back(s);
		s.c = mk_cmd(0, 0, 0, -1, -1, -1, 1, 1, 1); stim_tab.push_back(s);
		s.c = mk_cmd(0, 0, 0, 0, ONE, 0, 0, ONE, 0); stim_tab.push_back(s);
		s.c = mk_cmd(5, 6, 7, 0, 0, -ONE, 0, -ONE, 0); stim_tab.push_back(s);
		s.c = mk_cmd(-5, 0, 9, ONE, 0, 0, 0, 0, 0); stim_tab.push_back(s);
		s.c = mk_cmd(0, 0, 0, 3 * ONE, -4 * ONE, 12, mn, 1, mx); stim_tab.push_back(s);
		s.c = mk_cmd(0, 0, 0, mx, 0, 0, 0, mn, 0); stim_tab.push_back(s);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i])
			send_frame(stim_tab[i].c, stim_tab[i].typed, stim_tab[i].rows, 1'b1);
		// let the directed frames flush before random traffic
		drain_wait();

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) drain_wait();
			send_frame(rnd_cmd(), 1'b0, none, !(n >= 150 && n < 250));
		end

		drain_wait();
		repeat (LATENCY + 20) @(posedge clk);

		$display("%0d directed and %0d random frames, %0d beats checked, %0d degenerate",
			stim_tab.size(), N_RANDOM, beats_seen, degen_seen);
		if (errors == 0 && frame_rows_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/lafm_pkg.sv
hdl/lafm_norm.sv
hdl/lafm_cross.sv
hdl/lafm_rows.sv
hdl/look_at_frame_matrix_unit.sv
tb/look_at_frame_matrix_unit_tb.sv
